FILE: rtl/core/sbm_pkg.sv
// Shared types, codes and default sizes of the sparse block memory.
`default_nettype none

package sbm_pkg;

  // Default sizes. BLOCK_BYTES and TABLE_ENTRIES are powers of two.
  localparam int unsigned BLOCK_BYTES_DEF   = 64;
  localparam int unsigned TABLE_ENTRIES_DEF = 16;
  localparam int unsigned ADDR_WIDTH_DEF    = 32;
  localparam int unsigned PERM_WIDTH_DEF    = 3;

  // Request codes.
  localparam logic [1:0] REQ_CHECK = 2'd0;
  localparam logic [1:0] REQ_READ  = 2'd1;
  localparam logic [1:0] REQ_WRITE = 2'd2;

  // Status codes.
  localparam logic [1:0] STAT_OK     = 2'd0;
  localparam logic [1:0] STAT_ABSENT = 2'd1;
  localparam logic [1:0] STAT_FULL   = 2'd2;

  // Value of a byte that is absent or was never written.
  localparam logic [7:0] FILL_BYTE = 8'hCD;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] address;
    logic [7:0]  write_data;
    logic [2:0]  perm_bits;
    logic        last_byte;
  } req_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic [1:0] status;
    logic       last_out;
  } rsp_t;

endpackage

`default_nettype wire

FILE: rtl/core/sparse_block_memory.sv
// Sparse byte memory with a resident block table and demand allocation.
// Pipeline: s1, s2, response registers; the byte store has one read and one write port.
// Throughput: one transaction per cycle while responses are taken (rsp_ready).
// Reset: the block table is emptied at once, then a clearing pass over all
// TABLE_ENTRIES * BLOCK_BYTES words (1024 by default) clears the written
// marks of the byte store; no request is taken during that pass.
`default_nettype none

module sparse_block_memory #(
  parameter int unsigned BLOCK_BYTES   = sbm_pkg::BLOCK_BYTES_DEF,
  parameter int unsigned TABLE_ENTRIES = sbm_pkg::TABLE_ENTRIES_DEF,
  parameter int unsigned ADDR_WIDTH    = sbm_pkg::ADDR_WIDTH_DEF,
  parameter int unsigned PERM_WIDTH    = sbm_pkg::PERM_WIDTH_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_ready,
  input  wire sbm_pkg::req_t req,
  output logic               rsp_valid,
  input  wire logic          rsp_ready,
  output sbm_pkg::rsp_t      rsp
);

  localparam int unsigned OFF_W       = $clog2(BLOCK_BYTES);
  localparam int unsigned ENT_W       = $clog2(TABLE_ENTRIES);
  localparam int unsigned TAG_W       = ADDR_WIDTH - OFF_W;
  localparam int unsigned STORE_DEPTH = TABLE_ENTRIES * BLOCK_BYTES;
  localparam int unsigned IDX_W       = ENT_W + OFF_W;
  localparam logic [IDX_W-1:0] CLR_LAST = IDX_W'(STORE_DEPTH - 1);

  // One byte of the store with its written mark.
  typedef struct packed {
    logic       written;
    logic [7:0] data;
  } mem_word_t;

  // ---------------------------------------------------------------------
  // Block table: tags and permissions in flops, compared in parallel.
  // ---------------------------------------------------------------------
  logic [TAG_W-1:0]      block_tag   [TABLE_ENTRIES];
  logic [PERM_WIDTH-1:0] block_perm  [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] block_valid;

  // Byte store, one word per byte of every table entry.
  mem_word_t mem [STORE_DEPTH];
  mem_word_t mem_q;

  // Clearing pass over the written marks after reset.
  logic             clearing;
  logic [IDX_W-1:0] clr_cnt;

  // Pipeline: s1 looks up and accesses the store, s2 waits for read data,
  // the response register holds the finished transaction.
  logic          s1_valid;
  sbm_pkg::req_t s1_req;
  logic          s2_valid;
  logic          s2_is_read;
  logic          s2_hit;
  logic [1:0]    s2_status;
  logic          s2_last;

  // The whole pipeline moves when the response register is free or drains.
  logic adv;
  assign adv       = !rsp_valid || rsp_ready;
  assign req_ready = adv && !clearing;

  // ---------------------------------------------------------------------
  // Lookup for the transaction in s1.
  // ---------------------------------------------------------------------
  logic [ADDR_WIDTH-1:0] addr_ext;
  logic [TAG_W-1:0]      blk;
  logic [OFF_W-1:0]      off;
  logic [PERM_WIDTH-1:0] perm;
  logic [TABLE_ENTRIES-1:0] match;
  logic [ENT_W-1:0]      hit_idx;
  logic [ENT_W-1:0]      free_idx;
  logic                  hit;
  logic                  any_free;
  logic [ENT_W-1:0]      entry_sel;
  logic [IDX_W-1:0]      mem_idx;
  logic                  is_write;
  logic                  alloc;
  logic                  wr_en;
  logic [1:0]            s1_status;

  assign addr_ext = ADDR_WIDTH'(s1_req.address);
  assign blk      = addr_ext[ADDR_WIDTH-1:OFF_W];
  assign off      = addr_ext[OFF_W-1:0];
  assign perm     = PERM_WIDTH'(s1_req.perm_bits);

  always_comb begin
    match    = '0;
    hit_idx  = '0;
    free_idx = '0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      match[i] = block_valid[i] && (block_tag[i] == blk);
      if (match[i]) begin
        hit_idx = ENT_W'(i);
      end
    end
    // Walk down so the lowest free entry wins.
    for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
      if (!block_valid[i]) begin
        free_idx = ENT_W'(i);
      end
    end
  end

  assign hit       = |match;
  assign any_free  = !(&block_valid);
  assign entry_sel = hit ? hit_idx : free_idx;
  assign mem_idx   = {entry_sel, off};
  assign is_write  = s1_valid && (s1_req.req_type == sbm_pkg::REQ_WRITE);
  assign alloc     = adv && is_write && !hit && any_free;
  assign wr_en     = adv && is_write && (hit || any_free);

  always_comb begin
    case (s1_req.req_type)
      sbm_pkg::REQ_CHECK: begin
        s1_status = (!hit || ((block_perm[hit_idx] & perm) != perm)) ?
                    sbm_pkg::STAT_ABSENT : sbm_pkg::STAT_OK;
      end
      sbm_pkg::REQ_READ: begin
        s1_status = hit ? sbm_pkg::STAT_OK : sbm_pkg::STAT_ABSENT;
      end
      sbm_pkg::REQ_WRITE: begin
        s1_status = (hit || any_free) ? sbm_pkg::STAT_OK : sbm_pkg::STAT_FULL;
      end
      default: begin
        s1_status = sbm_pkg::STAT_OK;
      end
    endcase
  end

  // Allocate a table entry on a write miss. Entries are freed only at reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      block_valid <= '0;
    end else if (alloc) begin
      block_valid[free_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (alloc) begin
      block_tag[free_idx]  <= blk;
      block_perm[free_idx] <= perm;
    end
  end

  // ---------------------------------------------------------------------
  // Byte store: one write port (clearing pass or write), one read port.
  // A new entry's bytes still carry cleared marks since each entry is
  // allocated at most once per reset.
  // ---------------------------------------------------------------------
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  mem_word_t        mem_wdata;
  logic             mem_re;

  assign mem_we    = clearing || wr_en;
  assign mem_waddr = clearing ? clr_cnt : mem_idx;
  assign mem_wdata = clearing ? mem_word_t'('0) :
                     mem_word_t'{written: 1'b1, data: s1_req.write_data};
  assign mem_re    = adv && s1_valid;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_q <= mem[mem_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_cnt  <= '0;
    end else if (clearing) begin
      clr_cnt <= clr_cnt + 1'b1;
      if (clr_cnt == CLR_LAST) begin
        clearing <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Pipeline registers and response.
  // ---------------------------------------------------------------------
  logic [7:0] s2_rdata;

  // Absent blocks and unwritten bytes read as the fill byte.
  assign s2_rdata = s2_is_read ? ((s2_hit && mem_q.written) ? mem_q.data : sbm_pkg::FILL_BYTE)
                               : 8'h00;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      rsp_valid <= 1'b0;
    end else if (adv) begin
      s1_valid  <= req_valid && !clearing;
      s2_valid  <= s1_valid;
      rsp_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_req     <= req;
      s2_is_read <= s1_req.req_type == sbm_pkg::REQ_READ;
      s2_hit     <= hit;
      s2_status  <= s1_status;
      s2_last    <= s1_req.last_byte;
      rsp.read_data <= s2_rdata;
      rsp.status    <= s2_status;
      rsp.last_out  <= s2_last;
    end
  end

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_unique_hit: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> $onehot0(match))
    else $error("block resident in more than one table entry");

  a_alloc_free: assert property (@(posedge clk) disable iff (rst)
    alloc |-> !block_valid[free_idx] && !hit)
    else $error("allocation into a used entry or on a hit");

  a_alloc_sticks: assert property (@(posedge clk) disable iff (rst)
    alloc |=> block_valid[$past(free_idx)])
    else $error("allocated entry not marked valid");

  a_full_only: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && (s1_status == sbm_pkg::STAT_FULL)) |-> (&block_valid))
    else $error("table full reported with a free entry");

  a_clear_empty: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !s1_valid && !s2_valid && !rsp_valid)
    else $error("transaction in flight during clearing pass");

endmodule

`default_nettype wire
